// File: hw/rtl/ss_pkg.sv
`default_nettype none
package ss_pkg;

  localparam int WIN     = 16;
  localparam int WIN_W   = 4;
  localparam int OUT_CAP = 32;
  localparam int OUT_W   = 5;

  typedef struct packed {
    logic [7:0] character;
    logic       word_end;
  } ss_in_t;

  typedef struct packed {
    logic [7:0] stem_char;
    logic       stem_last;
    logic       stem_empty;
    logic       truncated;
  } ss_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_1A,
    ST_1B,
    ST_1BX,
    ST_1C,
    ST_2,
    ST_EMIT_RD,
    ST_EMIT_LD
  } ss_state_t;

  // prefix statistics: measure saturated at 2, has-vowel
  typedef struct packed {
    logic [1:0] m;
    logic       hv;
  } ss_stat_t;

  typedef struct packed {
    logic      load;
    logic      clear;
    ss_state_t step;
  } ss_ctl_t;

  localparam logic [7:0] CH_A = "a";
  localparam logic [7:0] CH_E = "e";
  localparam logic [7:0] CH_I = "i";
  localparam logic [7:0] CH_O = "o";
  localparam logic [7:0] CH_U = "u";
  localparam logic [7:0] CH_Y = "y";
  localparam logic [7:0] CH_S = "s";
  localparam logic [7:0] CH_L = "l";
  localparam logic [7:0] CH_Z = "z";
  localparam logic [7:0] CH_W = "w";
  localparam logic [7:0] CH_X = "x";
  localparam logic [7:0] CH_0 = "0";
  localparam logic [7:0] CH_9 = "9";
  localparam logic [7:0] CH_UA = "A";
  localparam logic [7:0] CH_UZ = "Z";

  // suffixes, last character in the low byte
  localparam logic [55:0] SFX_SSES = "sses";
  localparam logic [55:0] SFX_IES  = "ies";
  localparam logic [55:0] SFX_SS   = "ss";
  localparam logic [55:0] SFX_EED  = "eed";
  localparam logic [55:0] SFX_ED   = "ed";
  localparam logic [55:0] SFX_ING  = "ing";
  localparam logic [55:0] SFX_AT   = "at";
  localparam logic [55:0] SFX_BL   = "bl";
  localparam logic [55:0] SFX_IZ   = "iz";

  localparam logic [55:0] R2_SFX [6] = '{"ational", "ization", "iveness",
                                         "fulness", "ousness", "biliti"};
  localparam logic [2:0]  R2_LEN [6] = '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6};
  localparam logic [23:0] R2_REP [6] = '{"ate", "ize", "ive", "ful", "ous", "ble"};

  function automatic logic is_vowel(input logic [7:0] c);
    return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) || (c == CH_U);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/suffix_stemmer.sv
`default_nettype none
// suffix_stemmer: word stemmer, one character per input request
// in_data carries one byte and word_end; capitals fold to lower case and
// anything but a-z or 0-9 is dropped. Up to MAX_WORD characters are kept
// in a word memory, later ones are dropped and flagged as truncated.
// While characters load, the last 16 characters and their prefix
// measures are kept in a register window, so the suffix steps need no
// pass over the memory.
// Loading accepts one character per cycle. After the word_end request the
// steps 1a, 1b, 1b follow-up, 1c and 2 run in that order, one state each,
// then each stem character passes a memory read state and an output load
// state, at most 32 results per word. An empty stem gives one result
// with stem_empty set. in_stall stays high from word end until the final
// result is in the output register.
// When out_stall and out_valid are both high, the output register holds its
// result and the emit sequence waits. Reset (rst_n low, synchronous) empties
// the word and the output register; memory contents are not cleared.
module suffix_stemmer import ss_pkg::*; #(
  parameter int MAX_WORD = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire ss_in_t  in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output ss_out_t      out_data
);

  localparam int AW = $clog2(MAX_WORD);
  localparam int LW = $clog2(MAX_WORD + 1);

  ss_state_t        state_r, state_nxt;
  logic             ovf_r, ovf_nxt;
  logic [OUT_W-1:0] j_r, j_nxt;
  logic             ov_r, ov_nxt;
  ss_out_t          out_r, out_nxt;

  ss_ctl_t          ctl;
  logic [7:0]       c;
  logic             kept;
  logic             acc;
  logic [LW-1:0]    len;
  logic [WIN_W-1:0] drop;
  logic [7:0]       win_ch;
  logic [7:0]       rd_data;
  logic [LW-1:0]    nc;
  logic [7:0]       k8;
  logic             inwin;
  logic             empty;
  logic             last;
  logic             take;

  always_comb begin
    c = in_data.character;
    if (c >= CH_UA && c <= CH_UZ) c = c + 8'd32;
  end
  assign kept = (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9);
  assign acc  = in_valid && !in_stall;

  assign nc    = len - LW'(drop);
  assign empty = (nc == '0);
  assign last  = empty || ({3'b000, j_r} == 8'(nc) - 8'd1) || (j_r == OUT_W'(OUT_CAP - 1));
  assign k8    = 8'(len) - 8'd1 - 8'(j_r);
  assign inwin = k8 < 8'(WIN);
  assign take  = (state_r == ST_EMIT_LD) && (!ov_r || !out_stall);

  ss_tail #(.LW(LW)) u_tail (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .ch     (c),
    .k_sel  (k8[WIN_W-1:0]),
    .len    (len),
    .drop   (drop),
    .win_ch (win_ch)
  );

  ss_wordmem #(.DEPTH(MAX_WORD), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (ctl.load),
    .wr_addr (len[AW-1:0]),
    .wr_data (c),
    .rd_addr (AW'(j_r)),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:    if (acc && in_data.word_end) state_nxt = ST_1A;
      ST_1A:      state_nxt = ST_1B;
      ST_1B:      state_nxt = ST_1BX;
      ST_1BX:     state_nxt = ST_1C;
      ST_1C:      state_nxt = ST_2;
      ST_2:       state_nxt = ST_EMIT_RD;
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: if (take) state_nxt = last ? ST_LOAD : ST_EMIT_RD;
      default:    state_nxt = ST_LOAD;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall  = (state_r != ST_LOAD);
    ctl.load  = acc && kept && (len < LW'(MAX_WORD));
    ctl.clear = take && last;
    ctl.step  = state_r;
    ovf_nxt   = ovf_r;
    if (acc && kept && (len >= LW'(MAX_WORD))) ovf_nxt = 1'b1;
    if (ctl.clear) ovf_nxt = 1'b0;
    j_nxt   = j_r;
    ov_nxt  = ov_r && out_stall;
    out_nxt = out_r;
    if (state_r == ST_LOAD) j_nxt = '0;
    if (take) begin
      j_nxt              = j_r + OUT_W'(1);
      ov_nxt             = 1'b1;
      out_nxt.stem_char  = empty ? 8'd0 : (inwin ? win_ch : rd_data);
      out_nxt.stem_last  = last;
      out_nxt.stem_empty = empty;
      out_nxt.truncated  = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ovf_r   <= 1'b0;
      j_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      j_r     <= j_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: hw/rtl/ss_wordmem.sv
`default_nettype none
module ss_wordmem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ss_tail.sv
`default_nettype none
module ss_tail import ss_pkg::*; #(
  parameter int LW       = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ss_ctl_t          ctl,
  input  wire logic [7:0]       ch,
  input  wire logic [WIN_W-1:0] k_sel,
  output logic      [LW-1:0]    len,
  output logic      [WIN_W-1:0] drop,
  output logic      [7:0]       win_ch
);

  // window of the last characters, index 0 is the final one
  logic [WIN-1:0][7:0] wc_r, wc_nxt;
  logic [WIN-1:0]      cw_r, cw_nxt;
  ss_stat_t [WIN-1:0]  st_r, st_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [WIN_W-1:0]    d_r, d_nxt;
  logic                fol_r, fol_nxt;

  logic [LW-1:0]    nc;
  logic             cons_new;
  logic             inc;
  ss_stat_t         st_new;
  logic             found;
  logic [WIN_W-1:0] dn;
  logic [7:0]       lc;

  function automatic logic sfx_hit(input logic [WIN-1:0][7:0] w,
                                   input logic [WIN_W-1:0] d,
                                   input logic [55:0] s,
                                   input logic [2:0] n);
    logic hit;
    hit = 1'b1;
    for (int t = 0; t < 7; t++) begin
      if (3'(t) < n) begin
        if (w[WIN_W'(d + WIN_W'(t))] != s[8*t +: 8]) hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic [WIN_W-1:0] ix(input logic [WIN_W-1:0] d, input logic [2:0] o);
    return WIN_W'(d + WIN_W'(o));
  endfunction

  assign nc = len_r - LW'(d_r);
  assign lc = wc_r[d_r];

  always_comb begin
    wc_nxt  = wc_r;
    cw_nxt  = cw_r;
    st_nxt  = st_r;
    len_nxt = len_r;
    d_nxt   = d_r;
    fol_nxt = fol_r;
    found   = 1'b0;
    dn      = d_r;
    // letter class of the incoming character
    if (is_vowel(ch)) cons_new = 1'b0;
    else if (ch != CH_Y) cons_new = 1'b1;
    else if (len_r == '0) cons_new = 1'b1;
    else cons_new = !cw_r[0];
    inc = (len_r != '0) && !cw_r[0] && cons_new;
    st_new.hv = st_r[0].hv | !cons_new;
    st_new.m  = (inc && st_r[0].m != 2'd2) ? st_r[0].m + 2'd1 : st_r[0].m;

    if (ctl.clear) begin
      wc_nxt  = '0;
      cw_nxt  = '0;
      st_nxt  = '0;
      len_nxt = '0;
      d_nxt   = '0;
      fol_nxt = 1'b0;
    end else if (ctl.load) begin
      wc_nxt  = {wc_r[WIN-2:0], ch};
      cw_nxt  = {cw_r[WIN-2:0], cons_new};
      st_nxt  = {st_r[WIN-2:0], st_new};
      len_nxt = len_r + LW'(1);
    end else begin
      case (ctl.step)
        ST_1A: begin
          if (nc >= LW'(3) && lc == CH_S) begin
            if (sfx_hit(wc_r, d_r, SFX_SSES, 3'd4) || sfx_hit(wc_r, d_r, SFX_IES, 3'd3))
              d_nxt = d_r + WIN_W'(2);
            else if (!sfx_hit(wc_r, d_r, SFX_SS, 3'd2))
              d_nxt = d_r + WIN_W'(1);
          end
        end
        ST_1B: begin
          fol_nxt = 1'b0;
          if (nc >= LW'(3) && sfx_hit(wc_r, d_r, SFX_EED, 3'd3)) begin
            if (st_r[ix(d_r, 3'd3)].m != 2'd0) d_nxt = d_r + WIN_W'(1);
          end else if (nc >= LW'(2) && sfx_hit(wc_r, d_r, SFX_ED, 3'd2)
                       && st_r[ix(d_r, 3'd2)].hv) begin
            d_nxt   = d_r + WIN_W'(2);
            fol_nxt = 1'b1;
          end else if (nc >= LW'(3) && sfx_hit(wc_r, d_r, SFX_ING, 3'd3)
                       && st_r[ix(d_r, 3'd3)].hv) begin
            d_nxt   = d_r + WIN_W'(3);
            fol_nxt = 1'b1;
          end
        end
        ST_1BX: begin
          if (fol_r) begin
            if (nc >= LW'(2) && (sfx_hit(wc_r, d_r, SFX_AT, 3'd2)
                || sfx_hit(wc_r, d_r, SFX_BL, 3'd2) || sfx_hit(wc_r, d_r, SFX_IZ, 3'd2))) begin
              wc_nxt[d_r - WIN_W'(1)] = CH_E;
              d_nxt = d_r - WIN_W'(1);
            end else if (nc >= LW'(2) && lc == wc_r[ix(d_r, 3'd1)] && cw_r[d_r]) begin
              if (lc != CH_L && lc != CH_S && lc != CH_Z) d_nxt = d_r + WIN_W'(1);
            end else if (nc >= LW'(3) && st_r[d_r].m == 2'd1 && cw_r[d_r]
                         && !cw_r[ix(d_r, 3'd1)] && cw_r[ix(d_r, 3'd2)]
                         && lc != CH_W && lc != CH_X && lc != CH_Y) begin
              wc_nxt[d_r - WIN_W'(1)] = CH_E;
              d_nxt = d_r - WIN_W'(1);
            end
          end
        end
        ST_1C: begin
          if (nc >= LW'(1) && lc == CH_Y && st_r[ix(d_r, 3'd1)].hv) wc_nxt[d_r] = CH_I;
        end
        ST_2: begin
          for (int r = 0; r < 6; r++) begin
            if (!found && nc >= LW'(R2_LEN[r]) && sfx_hit(wc_r, d_r, R2_SFX[r], R2_LEN[r]))
            begin
              found = 1'b1;
              if (st_r[ix(d_r, R2_LEN[r])].m != 2'd0) begin
                dn = WIN_W'(d_r + WIN_W'(R2_LEN[r]) - WIN_W'(3));
                wc_nxt[dn]               = R2_REP[r][7:0];
                wc_nxt[dn + WIN_W'(1)]   = R2_REP[r][15:8];
                wc_nxt[dn + WIN_W'(2)]   = R2_REP[r][23:16];
                d_nxt = dn;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= '0;
      cw_r  <= '0;
      st_r  <= '0;
      len_r <= '0;
      d_r   <= '0;
      fol_r <= 1'b0;
    end else begin
      wc_r  <= wc_nxt;
      cw_r  <= cw_nxt;
      st_r  <= st_nxt;
      len_r <= len_nxt;
      d_r   <= d_nxt;
      fol_r <= fol_nxt;
    end
  end

  assign len    = len_r;
  assign drop   = d_r;
  assign win_ch = wc_r[k_sel];

endmodule
`default_nettype wire

// File: hw/rtl/ss_checker.sv
`default_nettype none
module ss_checker import ss_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_stall,
  input wire ss_in_t  in_data,
  input wire logic    out_valid,
  input wire logic    out_stall,
  input wire ss_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.word_end |=> in_stall)
    else $error("request taken during stemming");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stem_empty |-> out_data.stem_last && out_data.stem_char == 8'd0)
    else $error("empty stem result malformed");

  a_char_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stem_empty |->
      (out_data.stem_char >= CH_A && out_data.stem_char <= CH_Z) ||
      (out_data.stem_char >= CH_0 && out_data.stem_char <= CH_9))
    else $error("stem character out of class");

endmodule

bind suffix_stemmer ss_checker u_ss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
